@@ hdl/irr_pkg.sv @@
// ----------------------------------------------------------------------------
// irr_pkg: shared types and constants for the 90-degree image rotator
// Frame geometry, codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package irr_pkg;

  localparam int MAX_WIDTH    = 128;
  localparam int MAX_HEIGHT   = 128;
  localparam int CHANNEL_BITS = 8;

  localparam int COL_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_BITS    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ADDR_BITS   = ROW_BITS + COL_BITS;
  localparam int STORE_DEPTH = 1 << ADDR_BITS;
  localparam int PIXEL_BITS  = 3 * CHANNEL_BITS;
  localparam int DIM_BITS    = 8;

  localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(128);

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } irr_state_t;

  typedef struct packed {
    logic wr;
    logic rd;
    logic restart;
  } irr_cmd_t;

  typedef struct packed {
    logic load_last_col;
    logic load_last_row;
    logic emit_last_col;
    logic emit_last_row;
  } irr_status_t;

  // Clamped dimension minus one: zero acts as one, above maxv acts as maxv.
  function automatic logic [12:0] dim_m1(input logic [DIM_BITS-1:0] v, input int maxv);
    logic [12:0] r;
    if (v == '0) begin
      r = '0;
    end else if (32'(v) > maxv) begin
      r = 13'(maxv - 1);
    end else begin
      r = 13'(v) - 13'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/irr_ctrl.sv @@
// ----------------------------------------------------------------------------
// irr_ctrl: rotator controller
// Tracks load/drain phase and issues write, read and restart commands.
// ----------------------------------------------------------------------------
`default_nettype none

module irr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               op,
  input  wire logic               cfg_we,
  input  wire irr_pkg::irr_status_t status,
  output irr_pkg::irr_cmd_t       cmd,
  output logic                    busy
);

  irr_pkg::irr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= irr_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = irr_pkg::ST_LOAD;
    end else begin
      unique case (state_r)
        irr_pkg::ST_LOAD: begin
          if (start && op == irr_pkg::OP_WRITE &&
              status.load_last_col && status.load_last_row) begin
            state_nxt = irr_pkg::ST_DRAIN;
          end
        end
        irr_pkg::ST_DRAIN: begin
          if (start && op == irr_pkg::OP_READ &&
              status.emit_last_col && status.emit_last_row) begin
            state_nxt = irr_pkg::ST_LOAD;
          end
        end
        default: state_nxt = irr_pkg::ST_LOAD;
      endcase
    end
  end

  always_comb begin
    cmd.wr      = start && op == irr_pkg::OP_WRITE && state_r == irr_pkg::ST_LOAD;
    cmd.rd      = start && op == irr_pkg::OP_READ && state_r == irr_pkg::ST_DRAIN;
    cmd.restart = cfg_we || (cmd.rd && status.emit_last_col && status.emit_last_row);
    busy        = 1'b0;
  end

endmodule

`default_nettype wire

@@ hdl/irr_datapath.sv @@
// ----------------------------------------------------------------------------
// irr_datapath: rotator datapath
// Dimension registers, load/emit counters, frame store and output registers.
// ----------------------------------------------------------------------------
`default_nettype none

module irr_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire irr_pkg::irr_cmd_t                 cmd,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [irr_pkg::DIM_BITS-1:0]      cfg_data,
  input  wire logic [irr_pkg::CHANNEL_BITS-1:0]  red_in,
  input  wire logic [irr_pkg::CHANNEL_BITS-1:0]  green_in,
  input  wire logic [irr_pkg::CHANNEL_BITS-1:0]  blue_in,
  output irr_pkg::irr_status_t                   status,
  output logic                                   out_valid,
  output logic [irr_pkg::CHANNEL_BITS-1:0]       red_out,
  output logic [irr_pkg::CHANNEL_BITS-1:0]       green_out,
  output logic [irr_pkg::CHANNEL_BITS-1:0]       blue_out,
  output logic                                   end_of_row,
  output logic                                   end_of_frame
);

  localparam int CB = irr_pkg::CHANNEL_BITS;

  logic [irr_pkg::DIM_BITS-1:0] width_r, height_r;
  logic [irr_pkg::COL_BITS-1:0] w_m1;
  logic [irr_pkg::ROW_BITS-1:0] h_m1;

  logic [irr_pkg::ROW_BITS-1:0] load_row_r;
  logic [irr_pkg::COL_BITS-1:0] load_col_r;
  logic [irr_pkg::COL_BITS-1:0] emit_row_r;
  logic [irr_pkg::ROW_BITS-1:0] emit_col_r;
  logic [irr_pkg::ROW_BITS-1:0] src_row;

  logic [irr_pkg::PIXEL_BITS-1:0] mem [irr_pkg::STORE_DEPTH];
  logic [irr_pkg::PIXEL_BITS-1:0] rd_data_r;
  logic                           valid_r, eor_r, eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= irr_pkg::DIM_RESET;
      height_r <= irr_pkg::DIM_RESET;
    end else if (cfg_we) begin
      if (cfg_index == irr_pkg::REG_IMAGE_WIDTH) begin
        width_r <= cfg_data;
      end else begin
        height_r <= cfg_data;
      end
    end
  end

  always_comb begin
    w_m1 = irr_pkg::COL_BITS'(irr_pkg::dim_m1(width_r, irr_pkg::MAX_WIDTH));
    h_m1 = irr_pkg::ROW_BITS'(irr_pkg::dim_m1(height_r, irr_pkg::MAX_HEIGHT));
    status.load_last_col = load_col_r == w_m1;
    status.load_last_row = load_row_r == h_m1;
    status.emit_last_col = emit_col_r == h_m1;
    status.emit_last_row = emit_row_r == w_m1;
    src_row = h_m1 - emit_col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      load_row_r <= '0;
      load_col_r <= '0;
      emit_row_r <= '0;
      emit_col_r <= '0;
    end else begin
      if (cmd.wr) begin
        if (status.load_last_col) begin
          load_col_r <= '0;
          load_row_r <= status.load_last_row ? '0 :
                        load_row_r + irr_pkg::ROW_BITS'(1);
        end else begin
          load_col_r <= load_col_r + irr_pkg::COL_BITS'(1);
        end
      end
      if (cmd.rd) begin
        if (status.emit_last_col) begin
          emit_col_r <= '0;
          emit_row_r <= emit_row_r + irr_pkg::COL_BITS'(1);
        end else begin
          emit_col_r <= emit_col_r + irr_pkg::ROW_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[{load_row_r, load_col_r}] <= {red_in, green_in, blue_in};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_data_r <= mem[{src_row, emit_row_r}];
      eor_r     <= status.emit_last_col;
      eof_r     <= status.emit_last_col && status.emit_last_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.rd;
    end
  end

  assign out_valid    = valid_r;
  assign red_out      = rd_data_r[3*CB-1:2*CB];
  assign green_out    = rd_data_r[2*CB-1:CB];
  assign blue_out     = rd_data_r[CB-1:0];
  assign end_of_row   = eor_r;
  assign end_of_frame = eof_r;

endmodule

`default_nettype wire

@@ hdl/image_rotate_right_90.sv @@
// ----------------------------------------------------------------------------
// image_rotate_right_90: 90-degree clockwise RGB frame rotator
// Loads one frame in raster order, then drains it rotated.
// ----------------------------------------------------------------------------
// One item is accepted every clock: busy stays low. A write (op 0) stores
// the next pixel in raster order in a 128x128 single-port-write frame store;
// once the frame is full, each read (op 1) returns one rotated pixel, shown
// with out_valid for one cycle, in the cycle after the read is accepted (the
// frame-store read is registered). Results cannot be held off. Writes
// while a frame is held and reads before it is full are ignored.
// A dimension register write restarts the frame; store contents are kept.
`default_nettype none

module image_rotate_right_90 (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_op,
  input  wire logic [irr_pkg::CHANNEL_BITS-1:0]  in_red_in,
  input  wire logic [irr_pkg::CHANNEL_BITS-1:0]  in_green_in,
  input  wire logic [irr_pkg::CHANNEL_BITS-1:0]  in_blue_in,
  output logic                                   out_valid,
  output logic [irr_pkg::CHANNEL_BITS-1:0]       out_red_out,
  output logic [irr_pkg::CHANNEL_BITS-1:0]       out_green_out,
  output logic [irr_pkg::CHANNEL_BITS-1:0]       out_blue_out,
  output logic                                   out_end_of_row,
  output logic                                   out_end_of_frame,
  input  wire logic                              cfg_we,
  input  wire logic                              cfg_index,
  input  wire logic [irr_pkg::DIM_BITS-1:0]      cfg_data
);

  irr_pkg::irr_cmd_t    cmd;
  irr_pkg::irr_status_t status;

  irr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .op     (in_op),
    .cfg_we (cfg_we),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  irr_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .red_in       (in_red_in),
    .green_in     (in_green_in),
    .blue_in      (in_blue_in),
    .status       (status),
    .out_valid    (out_valid),
    .red_out      (out_red_out),
    .green_out    (out_green_out),
    .blue_out     (out_blue_out),
    .end_of_row   (out_end_of_row),
    .end_of_frame (out_end_of_frame)
  );

endmodule

`default_nettype wire

@@ hdl/irr_checker.sv @@
// ----------------------------------------------------------------------------
// irr_checker: port-level checks for the image rotator
// Result strobes versus accepted reads and frame-end flags.
// ----------------------------------------------------------------------------
`default_nettype none

module irr_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic in_op,
  input wire logic out_valid,
  input wire logic out_end_of_row,
  input wire logic out_end_of_frame
);

  a_result_needs_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_op == irr_pkg::OP_READ))
    else $error("result without an accepted read");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == irr_pkg::OP_WRITE) |=> !out_valid)
    else $error("result after a write transfer");

  a_eof_is_eor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_frame) |-> out_end_of_row)
    else $error("end of frame without end of row");

  a_eof_rearms: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_end_of_frame) |=> !out_valid)
    else $error("result right after end of frame");

endmodule

bind image_rotate_right_90 irr_checker u_irr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_op            (in_op),
  .out_valid        (out_valid),
  .out_end_of_row   (out_end_of_row),
  .out_end_of_frame (out_end_of_frame)
);

`default_nettype wire
